FILE: hdl/tua_pkg.sv
// shared types, constants and helpers for the texture unswizzle address core
`default_nettype none

package tua_pkg;

  localparam int COORD_BITS = 15;
  localparam int SIZE_W     = 16;
  localparam int PITCH_W    = 18;
  localparam int PB_W       = 3;
  localparam int OFFSET_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int NBITS_W    = 5;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [NBITS_W-1:0]    nbits_t;
  typedef logic [OFFSET_W-1:0]   offset_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_WIDTH      = 2'd0,
    CFG_TEX_HEIGHT     = 2'd1,
    CFG_DEST_ROW_PITCH = 2'd2,
    CFG_PIXEL_BYTES    = 2'd3
  } cfg_idx_t;

  localparam logic [SIZE_W-1:0]  TEX_WIDTH_RST      = 16'd256;
  localparam logic [SIZE_W-1:0]  TEX_HEIGHT_RST     = 16'd256;
  localparam logic [PITCH_W-1:0] DEST_ROW_PITCH_RST = 18'd1024;
  localparam logic [PB_W-1:0]    PIXEL_BYTES_RST    = 3'd4;

  // number of address bits needed to count below size
  function automatic nbits_t axis_bits(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] top;
    nbits_t            n;
    top = size - SIZE_W'(1);
    n   = '0;
    if (size > SIZE_W'(1)) begin
      for (int i = 0; i < SIZE_W; i++) begin
        if (top[i]) n = NBITS_W'(i + 1);
      end
    end
    return n;
  endfunction

  // low n bits set
  function automatic coord_t low_mask(input nbits_t n);
    coord_t m;
    for (int i = 0; i < COORD_BITS; i++) begin
      m[i] = (NBITS_W'(i) < n);
    end
    return m;
  endfunction

  // x to even bits, y to odd bits
  function automatic offset_t interleave(input coord_t x, input coord_t y);
    offset_t r;
    r = '0;
    for (int i = 0; i < COORD_BITS; i++) begin
      r[2*i]   = x[i];
      r[2*i+1] = y[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/texture_unswizzle_address_core.sv
// three-stage pipeline: morton swizzled offset and linear offset per pixel
// a result is presented once its input has passed the stage 1, stage 2 and stage 3 registers
// throughput: one pixel per cycle while out_stall is low; the three pipeline registers fill freely
// stalls back up stage by stage, so a bubble anywhere lets the input advance
// reset: rst_n low clears all stage valids and loads the size, pitch and
// pixel size registers with their defaults (256, 256, 1024, 4)
`default_nettype none

module texture_unswizzle_address_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tua_pkg::COORD_BITS-1:0] in_x_coord,
  input  wire logic [tua_pkg::COORD_BITS-1:0] in_y_coord,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tua_pkg::OFFSET_W-1:0]       out_swizzled_offset,
  output logic [tua_pkg::OFFSET_W-1:0]       out_linear_offset,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tua_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tua_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tua_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0]  tex_width_r;
  logic [SIZE_W-1:0]  tex_height_r;
  logic [PITCH_W-1:0] dest_row_pitch_r;
  logic [PB_W-1:0]    pixel_bytes_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r      <= TEX_WIDTH_RST;
      tex_height_r     <= TEX_HEIGHT_RST;
      dest_row_pitch_r <= DEST_ROW_PITCH_RST;
      pixel_bytes_r    <= PIXEL_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEX_WIDTH:      tex_width_r      <= cfg_data[SIZE_W-1:0];
        CFG_TEX_HEIGHT:     tex_height_r     <= cfg_data[SIZE_W-1:0];
        CFG_DEST_ROW_PITCH: dest_row_pitch_r <= cfg_data[PITCH_W-1:0];
        CFG_PIXEL_BYTES:    pixel_bytes_r    <= cfg_data[PB_W-1:0];
        default:            ;
      endcase
    end
  end

  // stage valids and advance enables
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // stage 1: axis bit counts and split of each coordinate
  nbits_t nx_nxt, ny_nxt;
  coord_t mx, my;
  coord_t lo_x_nxt, lo_y_nxt, tail_x_nxt, tail_y_nxt;

  always_comb begin
    nx_nxt     = axis_bits(tex_width_r);
    ny_nxt     = axis_bits(tex_height_r);
    mx         = low_mask(nx_nxt);
    my         = low_mask(ny_nxt);
    // bits below both counts interleave, the rest pack after the shorter axis
    lo_x_nxt   = in_x_coord & mx & my;
    lo_y_nxt   = in_y_coord & mx & my;
    tail_x_nxt = in_x_coord & mx & ~my;
    tail_y_nxt = in_y_coord & my & ~mx;
  end

  nbits_t nx_r, ny_r;
  coord_t lo_x_r, lo_y_r, tail_x_r, tail_y_r, x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      nx_r     <= nx_nxt;
      ny_r     <= ny_nxt;
      lo_x_r   <= lo_x_nxt;
      lo_y_r   <= lo_y_nxt;
      tail_x_r <= tail_x_nxt;
      tail_y_r <= tail_y_nxt;
      x1_r     <= in_x_coord;
      y1_r     <= in_y_coord;
    end
  end

  // stage 2: morton index and the two linear products
  offset_t                     morton_nxt;
  logic [COORD_BITS+PITCH_W-1:0] y_pitch_full;
  offset_t                     y_pitch_nxt;
  logic [COORD_BITS+PB_W-1:0]  x_bytes_nxt;

  always_comb begin
    morton_nxt = interleave(lo_x_r, lo_y_r)
               | (OFFSET_W'(tail_x_r) << ny_r)
               | (OFFSET_W'(tail_y_r) << nx_r);
    y_pitch_full = (COORD_BITS+PITCH_W)'(y1_r) * (COORD_BITS+PITCH_W)'(dest_row_pitch_r);
    y_pitch_nxt  = y_pitch_full[OFFSET_W-1:0];
    x_bytes_nxt  = (COORD_BITS+PB_W)'(x1_r) * (COORD_BITS+PB_W)'(pixel_bytes_r);
  end

  offset_t                    morton_r, y_pitch_r;
  logic [COORD_BITS+PB_W-1:0] x_bytes_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      morton_r  <= morton_nxt;
      y_pitch_r <= y_pitch_nxt;
      x_bytes_r <= x_bytes_nxt;
    end
  end

  // stage 3: scale by pixel size, final sum; offsets wrap at 32 bits
  logic [OFFSET_W+PB_W-1:0] sw_full;
  offset_t                  sw_nxt, lin_nxt;
  offset_t                  sw_r, lin_r;

  always_comb begin
    sw_full = (OFFSET_W+PB_W)'(morton_r) * (OFFSET_W+PB_W)'(pixel_bytes_r);
    sw_nxt  = sw_full[OFFSET_W-1:0];
    lin_nxt = y_pitch_r + OFFSET_W'(x_bytes_r);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      sw_r  <= sw_nxt;
      lin_r <= lin_nxt;
    end
  end

  assign out_valid           = v3_r;
  assign out_swizzled_offset = sw_r;
  assign out_linear_offset   = lin_r;

endmodule

`default_nettype wire

FILE: hdl/tua_checker.sv
// port-level checks for the texture unswizzle address core, bound to the top level
`default_nettype none

module tua_port_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [tua_pkg::OFFSET_W-1:0]  out_swizzled_offset,
  input wire logic [tua_pkg::OFFSET_W-1:0]  out_linear_offset
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // a held result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_swizzled_offset) && $stable(out_linear_offset))
    else $error("result changed while stalled");

  // input can only back up when a result is waiting at the output
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // an accepted pixel, or one ahead of it, is on offer after passing through the stage registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##3 out_valid)
    else $error("result missing after input transfer");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind texture_unswizzle_address_core tua_port_checker u_tua_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_swizzled_offset (out_swizzled_offset),
  .out_linear_offset   (out_linear_offset)
);

`default_nettype wire
